// ===== design/bqc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Biquad cascade package
// Widths, register indexes, reset coefficients, sequencer states and the
// control bundle shared by the biquad cascade modules.
// ----------------------------------------------------------------------------
package bqc_pkg;

	localparam int SECTIONS  = 4;
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int ACC_W     = 2 * DATA_W + 3;
	localparam int SEC_W     = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	localparam int CFG_IDX_W = 3;
	localparam int LATENCY   = 4 * SECTIONS + 1;

	typedef logic signed [DATA_W-1:0] word_t;

	localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

	localparam word_t RST_B0 = 32'sd6398;
	localparam word_t RST_B1 = 32'sd0;
	localparam word_t RST_B2 = -32'sd6398;
	localparam word_t RST_A1 = -32'sd99212;
	localparam word_t RST_A2 = 32'sd52739;

	localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		word_t b0;
		word_t b1;
		word_t b2;
		word_t a1;
		word_t a2;
	} coef_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_FB,
		ST_FF,
		ST_WB
	} state_t;

	typedef struct packed {
		logic             ld_in;
		logic             rd_en;
		logic [SEC_W-1:0] rd_addr;
		logic             mul_en;
		logic             fb_en;
		logic             ff_en;
		logic             wb_en;
		logic [SEC_W-1:0] wr_addr;
		logic             out_ld;
		logic             entry_vld;
	} ctl_t;

	// Clamp a wide signed value to the signed word range.
	function automatic word_t sat_word(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-DATA_W:0] top;
		top = v[ACC_W-1:DATA_W-1];
		if ((&top) || !(|top)) begin
			return v[DATA_W-1:0];
		end else if (v[ACC_W-1]) begin
			return WORD_MIN;
		end else begin
			return WORD_MAX;
		end
	endfunction

endpackage
`default_nettype wire

// ===== design/bqc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Biquad cascade channels
// Valid/ready channels for samples, results and coefficient writes.
// ----------------------------------------------------------------------------
interface bqc_in_if;
	logic               valid;
	logic               ready;
	bqc_pkg::word_t     sample_in;
	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqc_out_if;
	logic               valid;
	logic               ready;
	bqc_pkg::word_t     sample_out;
	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

interface bqc_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [bqc_pkg::CFG_IDX_W-1:0]     index;
	logic [bqc_pkg::DATA_W-1:0]        data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/bqc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bqc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [AW-1:0]         waddr,
	input  wire logic [WIDTH-1:0]      wdata,
	input  wire logic                  re,
	input  wire logic [AW-1:0]         raddr,
	output      logic [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ===== design/bqc_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Biquad cascade coefficient registers
// Holds b0, b1, b2, a1, a2; always ready for a write transfer.
// ----------------------------------------------------------------------------
module bqc_cfg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	bqc_cfg_if.sink             cfg,
	output      bqc_pkg::coef_t coef
);
	bqc_pkg::coef_t coef_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0 <= bqc_pkg::RST_B0;
			coef_q.b1 <= bqc_pkg::RST_B1;
			coef_q.b2 <= bqc_pkg::RST_B2;
			coef_q.a1 <= bqc_pkg::RST_A1;
			coef_q.a2 <= bqc_pkg::RST_A2;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				bqc_pkg::REG_B0: coef_q.b0 <= cfg.data;
				bqc_pkg::REG_B1: coef_q.b1 <= cfg.data;
				bqc_pkg::REG_B2: coef_q.b2 <= cfg.data;
				bqc_pkg::REG_A1: coef_q.a1 <= cfg.data;
				bqc_pkg::REG_A2: coef_q.a2 <= cfg.data;
				default: ;  // drop writes to unknown indexes
			endcase
		end
	end

	assign coef = coef_q;
endmodule
`default_nettype wire

// ===== design/bqc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Biquad cascade sequencer
// Walks the sections through read, multiply, feedback, feedforward and
// write-back steps; tracks which delay entries hold written data.
// ----------------------------------------------------------------------------
module bqc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output      logic          in_ready,
	input  wire logic          out_ready,
	output      logic          out_valid,
	output      bqc_pkg::ctl_t ctl
);
	bqc_pkg::state_t                state_q, state_d;
	logic [bqc_pkg::SEC_W-1:0]      sec_q;
	logic [bqc_pkg::SECTIONS-1:0]   vld_q;
	logic                           entry_vld_s1;
	logic                           out_valid_q;
	logic                           last;
	logic                           stall;

	assign last     = (sec_q == bqc_pkg::SEC_W'(bqc_pkg::SECTIONS - 1));
	assign stall    = out_valid_q && !out_ready;
	assign in_ready = (state_q == bqc_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bqc_pkg::ST_IDLE: if (in_valid) state_d = bqc_pkg::ST_MUL;
			bqc_pkg::ST_MUL:  state_d = bqc_pkg::ST_FB;
			bqc_pkg::ST_FB:   state_d = bqc_pkg::ST_FF;
			bqc_pkg::ST_FF:   state_d = bqc_pkg::ST_WB;
			bqc_pkg::ST_WB: begin
				if (!last) begin
					state_d = bqc_pkg::ST_MUL;
				end else if (!stall) begin
					state_d = bqc_pkg::ST_IDLE;
				end
			end
			default: state_d = bqc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl           = '0;
		ctl.wr_addr   = sec_q;
		ctl.entry_vld = entry_vld_s1;
		unique case (state_q)
			bqc_pkg::ST_IDLE: begin
				ctl.ld_in   = in_valid;
				ctl.rd_en   = in_valid;
				ctl.rd_addr = '0;
			end
			bqc_pkg::ST_MUL: ctl.mul_en = 1'b1;
			bqc_pkg::ST_FB:  ctl.fb_en  = 1'b1;
			bqc_pkg::ST_FF:  ctl.ff_en  = 1'b1;
			bqc_pkg::ST_WB: begin
				// hold the last section until the result register frees up
				ctl.wb_en   = !(last && stall);
				ctl.out_ld  = last && !stall;
				ctl.rd_en   = !last;
				ctl.rd_addr = sec_q + 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bqc_pkg::ST_IDLE;
			sec_q        <= '0;
			vld_q        <= '0;
			entry_vld_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bqc_pkg::ST_IDLE && in_valid) begin
				sec_q <= '0;
			end else if (state_q == bqc_pkg::ST_WB && !last) begin
				sec_q <= sec_q + 1'b1;
			end
			if (ctl.wb_en) begin
				vld_q[ctl.wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				entry_vld_s1 <= vld_q[ctl.rd_addr];
			end
			if (ctl.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/bqc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Biquad cascade datapath
// Per-section multiply, feedback and feedforward arithmetic with
// registered products, saturation, and the result register.
// ----------------------------------------------------------------------------
module bqc_datapath (
	input  wire logic                            clk,
	input  wire bqc_pkg::coef_t                  coef,
	input  wire bqc_pkg::ctl_t                   ctl,
	input  wire bqc_pkg::word_t                  sample_in,
	input  wire logic [2*bqc_pkg::DATA_W-1:0]    ram_rdata,
	output      logic [2*bqc_pkg::DATA_W-1:0]    ram_wdata,
	output      bqc_pkg::word_t                  sample_out
);
	bqc_pkg::word_t                             wn, wo;
	bqc_pkg::word_t                             y_q, wn_q, w0_q, out_q;
	logic signed [bqc_pkg::PROD_W-1:0]          pa1_q, pa2_q, pb1_q, pb2_q, pb0_q;
	logic signed [bqc_pkg::ACC_W-1:0]           pre_q;
	logic signed [bqc_pkg::DATA_W+bqc_pkg::FRAC_BITS-1:0] y_ext;
	logic signed [bqc_pkg::ACC_W-1:0]           fb_sum, ff_sum;
	bqc_pkg::word_t                             w0_sat, ff_sat;

	// Entries never written read as zero.
	assign wn = ctl.entry_vld ? ram_rdata[2*bqc_pkg::DATA_W-1:bqc_pkg::DATA_W] : '0;
	assign wo = ctl.entry_vld ? ram_rdata[bqc_pkg::DATA_W-1:0] : '0;

	// y - floor(fb/2^F) == floor((y*2^F + 2^F-1 - fb) / 2^F)
	assign y_ext  = {y_q, {bqc_pkg::FRAC_BITS{1'b1}}};
	assign fb_sum = bqc_pkg::ACC_W'(y_ext) - bqc_pkg::ACC_W'(pa1_q)
		- bqc_pkg::ACC_W'(pa2_q);
	assign w0_sat = bqc_pkg::sat_word(fb_sum >>> bqc_pkg::FRAC_BITS);

	assign ff_sum = bqc_pkg::ACC_W'(pb0_q) + pre_q;
	assign ff_sat = bqc_pkg::sat_word(ff_sum >>> bqc_pkg::FRAC_BITS);

	always_ff @(posedge clk) begin
		if (ctl.ld_in) begin
			y_q <= sample_in;
		end else if (ctl.wb_en) begin
			y_q <= ff_sat;
		end
		if (ctl.mul_en) begin
			pa1_q <= coef.a1 * wn;
			pa2_q <= coef.a2 * wo;
			pb1_q <= coef.b1 * wn;
			pb2_q <= coef.b2 * wo;
			wn_q  <= wn;
		end
		if (ctl.fb_en) begin
			w0_q  <= w0_sat;
			pre_q <= bqc_pkg::ACC_W'(pb1_q) + bqc_pkg::ACC_W'(pb2_q);
		end
		if (ctl.ff_en) begin
			pb0_q <= coef.b0 * w0_q;
		end
		if (ctl.out_ld) begin
			out_q <= ff_sat;
		end
	end

	// shift the delay line: older <- newer, newer <- w0
	assign ram_wdata  = {w0_q, wn_q};
	assign sample_out = out_q;
endmodule
`default_nettype wire

// ===== design/biquad_cascade_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Biquad cascade filter
// Direct form II second-order sections in series, sharing one coefficient
// set; the delay words of all sections live in one RAM.
// ----------------------------------------------------------------------------
// Samples: one sample is in flight at a time; each section takes four steps
//   around the delay RAM (read, multiply, feedback, feedforward/write), and the
//   result is offered once the last section's write-back loads the result register.
// A result waiting at the output does not block the next input transfer.
// Reset: coefficients return to defaults; per-entry valid flags make all delay
//   words read as zero, with no clearing pass.
module biquad_cascade_filter (
	input  wire logic clk,
	input  wire logic arst_n,
	bqc_cfg_if.sink   cfg,
	bqc_in_if.sink    samples,
	bqc_out_if.source results
);
	bqc_pkg::coef_t                    coef;
	bqc_pkg::ctl_t                     ctl;
	logic [2*bqc_pkg::DATA_W-1:0]      ram_rdata;
	logic [2*bqc_pkg::DATA_W-1:0]      ram_wdata;

	bqc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.coef   (coef)
	);

	bqc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_ready (results.ready),
		.out_valid (results.valid),
		.ctl       (ctl)
	);

	bqc_ram #(
		.WIDTH (2 * bqc_pkg::DATA_W),
		.DEPTH (bqc_pkg::SECTIONS)
	) u_delay_ram (
		.clk   (clk),
		.we    (ctl.wb_en),
		.waddr (ctl.wr_addr),
		.wdata (ram_wdata),
		.re    (ctl.rd_en),
		.raddr (ctl.rd_addr),
		.rdata (ram_rdata)
	);

	bqc_datapath u_datapath (
		.clk        (clk),
		.coef       (coef),
		.ctl        (ctl),
		.sample_in  (samples.sample_in),
		.ram_rdata  (ram_rdata),
		.ram_wdata  (ram_wdata),
		.sample_out (results.sample_out)
	);
endmodule
`default_nettype wire

// ===== design/bqc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Biquad cascade checker
// Port-level checks on sequencing and result timing, bound to the top level.
// ----------------------------------------------------------------------------
module bqc_checker (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [bqc_pkg::DATA_W-1:0] sample_out
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(sample_out))
		else $error("stalled result changed");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a sample is in flight");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |-> ##(bqc_pkg::LATENCY) out_valid)
		else $error("result not offered on time");
endmodule

bind biquad_cascade_filter bqc_checker u_bqc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (samples.valid),
	.in_ready   (samples.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.sample_out (results.sample_out)
);
`default_nettype wire

// ===== tb/sv/biquad_response_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad cascade response checker
// Watches the coefficient, sample and result channels, runs its own copy of
// the fixed-point section cascade on every sample transfer and compares each
// result transfer against the oldest predicted output.
// ----------------------------------------------------------------------------
module biquad_response_checker (
	input  logic clk,
	input  logic arst_n,
	bqc_cfg_if   cfg,
	bqc_in_if    samples,
	bqc_out_if   results,
	output int   fail_count,
	output int   pending_count
);
	import bqc_pkg::*;

	word_t fwd0;
	word_t fwd1;
	word_t fwd2;
	word_t fbk1;
	word_t fbk2;
	word_t delay_new [SECTIONS];
	word_t delay_old [SECTIONS];
	word_t predicted_out [$];
	word_t predicted;
	word_t oldest;
	int    fails;

	function automatic word_t clamp_word(input logic signed [ACC_W:0] v);
		if (v > WORD_MAX) begin
			return WORD_MAX;
		end else if (v < WORD_MIN) begin
			return WORD_MIN;
		end
		return v[DATA_W-1:0];
	endfunction

	// Sum of products is exact at this width; the shift floors it.
	task automatic run_cascade(input word_t x, output word_t y);
		logic signed [ACC_W:0] acc;
		word_t wn;
		word_t wo;
		word_t w0;
		word_t v;
		v = x;
		for (int s = 0; s < SECTIONS; s++) begin
			wn = delay_new[s];
			wo = delay_old[s];
			acc = fbk1 * wn + fbk2 * wo;
			acc = v - (acc >>> FRAC_BITS);
			w0 = clamp_word(acc);
			acc = fwd0 * w0 + fwd1 * wn + fwd2 * wo;
			v = clamp_word(acc >>> FRAC_BITS);
			delay_old[s] = wn;
			delay_new[s] = w0;
		end
		y = v;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd0 = RST_B0;
			fwd1 = RST_B1;
			fwd2 = RST_B2;
			fbk1 = RST_A1;
			fbk2 = RST_A2;
			for (int s = 0; s < SECTIONS; s++) begin
				delay_new[s] = '0;
				delay_old[s] = '0;
			end
			predicted_out.delete();
			fails = 0;
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_B0: fwd0 = cfg.data;
					REG_B1: fwd1 = cfg.data;
					REG_B2: fwd2 = cfg.data;
					REG_A1: fbk1 = cfg.data;
					REG_A2: fbk2 = cfg.data;
					default: ;
				endcase
			end
			// Check results before queueing this cycle's sample.
			if (results.valid && results.ready) begin
				if (predicted_out.size() == 0) begin
					$error("sample_out: expected none, actual %0d", results.sample_out);
					fails++;
				end else begin
					oldest = predicted_out.pop_front();
					if (results.sample_out !== oldest) begin
						$error("sample_out: expected %0d, actual %0d",
							oldest, results.sample_out);
						fails++;
					end
				end
			end
			if (samples.valid && samples.ready) begin
				run_cascade(samples.sample_in, predicted);
				predicted_out.push_back(predicted);
			end
			pending_count <= predicted_out.size();
			fail_count <= fails;
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad cascade filter testbench
// Drives corner samples at the reset coefficients, then phases of random
// samples under a series of coefficient sets, with random idling on both
// channels; the response checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
	import bqc_pkg::*;

	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 130;
	localparam int RESET_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 1_000_000;

	typedef enum int {
		COEF_DEFAULT,
		COEF_ALL_MAX,
		COEF_ALL_MIN,
		COEF_PASS,
		COEF_RANDOM,
		COEF_GENTLE,
		COEF_ZERO,
		COEF_CORNERS,
		COEF_KINDS
	} coef_kind_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic idle_on = 1'b0;
	int   fail_count;
	int   pending_count;
	int   sent = 0;
	int   writes = 0;
	int   settings = 0;
	int   cycle_count;
	int   stall_left = 0;

	word_t corner_samples [$] = '{
		32'sd0, 32'sd1, -32'sd1, WORD_MAX, WORD_MIN, 32'sd65536, -32'sd65536,
		WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
		WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
		WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN,
		32'sd0, 32'sd0, 32'sd0
	};

	always #2 clk = ~clk;

	bqc_cfg_if cfg_ch ();
	bqc_in_if  in_ch ();
	bqc_out_if out_ch ();

	biquad_cascade_filter u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.samples (in_ch),
		.results (out_ch)
	);

	biquad_response_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_ch),
		.samples       (in_ch),
		.results       (out_ch),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	function automatic int pick_gap();
		if ($urandom_range(0, 9) != 0) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(20, 80);
	endfunction

	function automatic word_t pick_sample();
		word_t v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: v = WORD_MAX;
					1: v = WORD_MIN;
					2: v = '0;
					default: v = '1;
				endcase
			end
			1, 2, 3: v = $urandom;
			// within +-4.0 in Q16
			default: v = int'($urandom_range(0, 1 << 19)) - (1 << 18);
		endcase
		return v;
	endfunction

	function automatic word_t pick_coef(input coef_kind_e kind,
			input logic [CFG_IDX_W-1:0] idx);
		word_t v;
		case (kind)
			COEF_DEFAULT: begin
				case (idx)
					REG_B0: v = RST_B0;
					REG_B1: v = RST_B1;
					REG_B2: v = RST_B2;
					REG_A1: v = RST_A1;
					default: v = RST_A2;
				endcase
			end
			COEF_ALL_MAX: v = WORD_MAX;
			COEF_ALL_MIN: v = WORD_MIN;
			COEF_PASS:    v = (idx == REG_B0) ? word_t'(1 << FRAC_BITS) : '0;
			COEF_RANDOM:  v = $urandom;
			COEF_GENTLE:  v = int'($urandom_range(0, 1 << 18)) - (1 << 17);
			COEF_ZERO:    v = '0;
			default: begin
				case ($urandom_range(0, 3))
					0: v = WORD_MAX;
					1: v = WORD_MIN;
					2: v = '1;
					default: v = 32'sd1;
				endcase
			end
		endcase
		return v;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		writes++;
	endtask

	// Lead with a write to an unused index; it must change nothing.
	task automatic load_setting(input coef_kind_e kind);
		logic [CFG_IDX_W-1:0] idx;
		idx = $urandom_range(2 ** CFG_IDX_W - 1, REG_A2 + 1);
		write_reg(idx, $urandom);
		for (int r = REG_B0; r <= REG_A2; r++) begin
			idx = r;
			write_reg(idx, pick_coef(kind, idx));
		end
		cfg_ch.valid <= 1'b0;
		settings++;
	endtask

	task automatic send_sample(input word_t value);
		int gap;
		gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.sample_in <= value;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sent++;
	endtask

	// Hold off until every predicted output has been transferred.
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			stall_left = pick_gap() - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.sample_in = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		out_ch.ready = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		idle_on <= 1'b1;
		@(posedge clk);
		settings = 1;
		foreach (corner_samples[i]) send_sample(corner_samples[i]);
		for (int p = 0; p < PHASES; p++) begin
			drain();
			idle_on <= (p % 3) != 2;
			load_setting((p < COEF_KINDS) ? coef_kind_e'(p)
				: coef_kind_e'($urandom_range(0, COEF_KINDS - 1)));
			repeat (PHASE_ITEMS) send_sample(pick_sample());
		end
		drain();
		repeat (4 * LATENCY) @(posedge clk);
		$display("covered %0d samples under %0d coefficient sets, %0d register writes",
			sent, settings, writes);
		$display("unused register indexes written once per set; idling off every third set");
		if (pending_count != 0) begin
			$error("sample_out: %0d predicted outputs never transferred", pending_count);
		end
		if (fail_count == 0 && pending_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("status: fail");
		$finish;
	end

endmodule
